[rtl/tcm_pkg.sv]
// Shared types and constants for the tempo change map.
// Request codes, controller states and the command/status bundles
// passed between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcm_pkg;

  // Fixed field widths
  localparam int TICK_W     = 32;
  localparam int TEMPO_W    = 16;
  localparam int REQ_W      = 2;
  localparam int COUNT_W    = 5;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 32;

  // Request codes carried on tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EVAL,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the request, set up counters
    logic read;    // issue a table read for the current entry
    logic eval;    // act on the entry just read
    logic finish;  // commit the request and present the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic loop_end;  // no more entries to visit
    logic eval_stop; // entry just read ends the walk
    logic out_busy;  // result register still waits to be taken
  } stat_t;

endpackage

`default_nettype wire

[rtl/tcm_ctrl.sv]
// Controller of the tempo change map: sequences load, entry walk and commit.
// Depends on tcm_pkg for state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module tcm_ctrl import tcm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = stat.loop_end ? ST_FINISH : ST_EVAL;
      end
      ST_EVAL: begin
        state_next = stat.eval_stop ? ST_FINISH : ST_CHECK;
      end
      ST_FINISH: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load      = s_axis_tvalid;
      end
      ST_CHECK: begin
        cmd.read = !stat.loop_end;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Commit never overwrites a result still waiting downstream
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !stat.out_busy) else $error("commit while result pending");

  // A read is always followed by its evaluation
  a_read_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.read |=> (state == ST_EVAL)) else $error("read not evaluated");

  // Only one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("overlapping commands");

endmodule

`default_nettype wire

[rtl/tcm_datapath.sv]
// Datapath of the tempo change map: entry memory, walk counters, result register.
// Depends on tcm_pkg; driven by tcm_ctrl through cmd_t / stat_t.
`timescale 1ns / 1ps
`default_nettype none

module tcm_datapath import tcm_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  input  wire logic [REQ_W-1:0]     s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  input  wire cmd_t                 cmd,
  output stat_t                     stat
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EW = TICK_W + TEMPO_W;

  // Entry store: {tick, tempo}
  logic [EW-1:0] mem [TABLE_DEPTH];

  logic [CW-1:0]      held;
  logic [REQ_W-1:0]   op;
  logic [TICK_W-1:0]  req_tick;
  logic [TEMPO_W-1:0] req_tempo;
  logic               full_flag;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      wr_idx;
  logic [TICK_W-1:0]  rd_tick;
  logic [TEMPO_W-1:0] rd_tempo;
  logic               q_found;
  logic [TEMPO_W-1:0] q_tempo;

  logic [CW-1:0]      idx_dec;
  logic [CW-1:0]      idx_inc;
  logic               match;
  logic [CW-1:0]      rd_addr;
  logic               mem_we;
  logic [CW-1:0]      mem_waddr;
  logic [EW-1:0]      mem_wdata;
  logic [CW-1:0]      held_next;
  logic [31:0]        held_wide;
  logic [31:0]        removed_wide;
  logic [COUNT_W-1:0] res_count;
  logic [COUNT_W-1:0] res_removed;
  logic               res_found;
  logic [TEMPO_W-1:0] res_tempo;
  logic               res_full;

  assign idx_dec = idx - CW'(1);
  assign idx_inc = idx + CW'(1);
  assign match   = (rd_tick == req_tick) && (rd_tempo == req_tempo);

  // Walk status per request type
  always_comb begin
    stat.out_busy = m_axis_tvalid && !m_axis_tready;
    rd_addr       = idx;
    unique case (op)
      REQ_INSERT: begin
        stat.loop_end  = full_flag || (idx == '0);
        stat.eval_stop = (rd_tick <= req_tick);
        rd_addr        = idx_dec;
      end
      REQ_DELETE: begin
        stat.loop_end  = (idx == held);
        stat.eval_stop = 1'b0;
      end
      REQ_QUERY: begin
        stat.loop_end  = (idx == held);
        stat.eval_stop = (rd_tick > req_tick);
      end
      default: begin
        stat.loop_end  = 1'b1;
        stat.eval_stop = 1'b0;
      end
    endcase
  end

  // Table write: shift up on insert, compact on delete, place new entry at commit
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = {rd_tick, rd_tempo};
    if (cmd.eval) begin
      if (op == REQ_INSERT && !stat.eval_stop) begin
        mem_we = 1'b1;
      end else if (op == REQ_DELETE && !match) begin
        mem_we    = 1'b1;
        mem_waddr = wr_idx;
      end
    end else if (cmd.finish && op == REQ_INSERT && !full_flag) begin
      mem_we    = 1'b1;
      mem_wdata = {req_tick, req_tempo};
    end
  end

  // Count after this request, and result fields
  always_comb begin
    held_next   = held;
    res_found   = 1'b0;
    res_tempo   = '0;
    res_full    = 1'b0;
    removed_wide = '0;
    unique case (op)
      REQ_INSERT: begin
        res_full = full_flag;
        if (!full_flag) held_next = held + CW'(1);
      end
      REQ_DELETE: begin
        held_next    = wr_idx;
        removed_wide = 32'(held - wr_idx);
      end
      REQ_QUERY: begin
        res_found = q_found;
        res_tempo = q_tempo;
      end
      default: begin
        held_next = held;
      end
    endcase
    held_wide   = 32'(held_next);
    res_count   = held_wide[COUNT_W-1:0];
    res_removed = removed_wide[COUNT_W-1:0];
  end

  // Memory port and registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr[AW-1:0]] <= mem_wdata;
    if (cmd.read) {rd_tick, rd_tempo} <= mem[rd_addr[AW-1:0]];
  end

  // Control state: entry count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      held          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        held          <= held_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Request capture, walk counters and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= s_axis_tuser;
      req_tick  <= s_axis_tdata[TICK_W-1:0];
      req_tempo <= s_axis_tdata[TICK_W +: TEMPO_W];
      full_flag <= (held == CW'(TABLE_DEPTH));
      idx       <= (s_axis_tuser == REQ_INSERT) ? held : '0;
      wr_idx    <= '0;
      q_found   <= 1'b0;
      q_tempo   <= '0;
    end else if (cmd.eval) begin
      unique case (op)
        REQ_INSERT: begin
          if (!stat.eval_stop) idx <= idx_dec;
        end
        REQ_DELETE: begin
          idx <= idx_inc;
          if (!match) wr_idx <= wr_idx + CW'(1);
        end
        REQ_QUERY: begin
          if (!stat.eval_stop) begin
            q_found <= 1'b1;
            q_tempo <= rd_tempo;
            idx     <= idx_inc;
          end
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
    if (cmd.finish) begin
      m_axis_tdata <= {4'b0, res_count, res_removed, res_full, res_tempo, res_found};
    end
  end

  // Table never holds more than its depth
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(TABLE_DEPTH)) else $error("entry count over depth");

  // Compaction write pointer never passes the read pointer
  a_wr_behind: assert property (@(posedge clk) disable iff (rst)
    (op == REQ_DELETE && (cmd.eval || cmd.finish)) |-> (wr_idx <= idx))
    else $error("delete write pointer ahead of read pointer");

  // A commit always presents a result
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_axis_tvalid) else $error("commit without result");

endmodule

`default_nettype wire

[rtl/tempo_change_map.sv]
// Top level of the tempo change map: tick-sorted tempo table with
// insert, delete and query. Instantiates tcm_ctrl and tcm_datapath; uses tcm_pkg.
//
//  Channel   Direction  Handshake                    Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser: req_type; tdata: tick, tempo_value
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: found, tempo_out, table_full,
//                                                     removed_count, entry_count
//
// One request at a time; each entry visited takes a table read, then an
// evaluation. Insert walks down from the last entry, shifting each later tick
// up, and stops at an entry at or before its tick; a full table is not walked.
// Delete visits every entry. Query visits the entries at or before the tick and
// stops at the first later one. Request types with no meaning visit no entry.
// Reset empties the table at once (entry count to zero); no clearing pass.
// A new request is taken while the previous result waits; commit stalls until
// the result register is free.
`timescale 1ns / 1ps
`default_nettype none

module tempo_change_map import tcm_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // tick [31:0], tempo_value [47:32]
  input  wire logic [REQ_W-1:0]     s_axis_tuser,  // req_type [1:0]
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata   // found [0], tempo_out [16:1],
                                                   // table_full [17], removed_count [22:18],
                                                   // entry_count [27:23], zero [31:28]
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  tcm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // Table and result register
  tcm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

`default_nettype wire
